/* hw/rtl/lrup_pkg.sv */
// Package for the LRU frame table with pinning.
// Holds widths, operation and status codes, and the controller/datapath command type.
`timescale 1ns / 1ps
package lrup_pkg;
   localparam int ENTRIES_DEF    = 64;
   localparam int PAGE_BITS_DEF  = 32;
   localparam int TABLE_BITS_DEF = 16;
   localparam int FRAME_W        = 6;

   typedef enum logic [1:0] {
      OP_ADD   = 2'd0,
      OP_EVICT = 2'd1,
      OP_TOUCH = 2'd2,
      OP_FLAGS = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_PINNED   = 2'd2,
      ST_NOTFOUND = 2'd3
   } status_type;

   // Command from the controller to the datapath.
   typedef struct packed {
      logic capture;   // latch the request word
      logic commit;    // apply the update chosen from the search results
   } cmd_type;
endpackage

/* hw/rtl/lru_replacement_with_pinning.sv */
// LRU frame table with pinning: add, evict-and-replace, touch and set-flags.
// A word accepted in the idle state is captured, then searched and committed in the execute
// state once the result register is free, which also loads its result word. The controller
// takes no new word until the previous one has been committed.
// Reset clears all valid and flag bits, the controller and the result valid.
`timescale 1ns / 1ps
module lru_replacement_with_pinning
   import lrup_pkg::*;
#(
   parameter int ENTRIES    = ENTRIES_DEF,
   parameter int PAGE_BITS  = PAGE_BITS_DEF,
   parameter int TABLE_BITS = TABLE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [15:0] req_table_id,
   input  logic [31:0] req_page_number,
   input  logic        req_new_pinned,
   input  logic        req_new_anonymous,
   input  logic        req_new_has_handles,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [5:0]  rsp_frame,
   output logic        rsp_write_back,
   output logic [15:0] rsp_victim_table_id,
   output logic [31:0] rsp_victim_page_number
);
   cmd_type     cmd;
   logic        load_rsp;
   logic [1:0]  r_status;
   logic [5:0]  r_frame;
   logic        r_wb;
   logic [15:0] r_vt;
   logic [31:0] r_vp;

   // The controller accepts a word, then commits it once the result
   // register is free, so a waiting result never blocks the datapath mid-update.
   lrup_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .cmd, .load_rsp
   );

   lrup_datapath #(.ENTRIES(ENTRIES), .PAGE_BITS(PAGE_BITS), .TABLE_BITS(TABLE_BITS)) u_dp (
      .clock, .reset, .cmd,
      .req_operation, .req_table_id, .req_page_number,
      .req_new_pinned, .req_new_anonymous, .req_new_has_handles,
      .res_status(r_status), .res_frame(r_frame), .res_write_back(r_wb),
      .res_victim_table_id(r_vt), .res_victim_page_number(r_vp)
   );

   // Result register; it holds while the consumer stalls.
   logic [1:0]  status_ff;
   logic [5:0]  frame_ff;
   logic        wb_ff;
   logic [15:0] vt_ff;
   logic [31:0] vp_ff;
   always_ff @(posedge clock) begin
      if (load_rsp) begin
         status_ff <= r_status;
         frame_ff  <= r_frame;
         wb_ff     <= r_wb;
         vt_ff     <= r_vt;
         vp_ff     <= r_vp;
      end
   end
   assign rsp_status             = status_ff;
   assign rsp_frame              = frame_ff;
   assign rsp_write_back         = wb_ff;
   assign rsp_victim_table_id    = vt_ff;
   assign rsp_victim_page_number = vp_ff;
endmodule

/* hw/rtl/lrup_datapath.sv */
// Datapath of the LRU frame table: entry registers, search and recency update.
// Depends on lrup_pkg.
`timescale 1ns / 1ps
module lrup_datapath
   import lrup_pkg::*;
#(
   parameter int ENTRIES    = ENTRIES_DEF,
   parameter int PAGE_BITS  = PAGE_BITS_DEF,
   parameter int TABLE_BITS = TABLE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   input  logic [1:0]  req_operation,
   input  logic [15:0] req_table_id,
   input  logic [31:0] req_page_number,
   input  logic        req_new_pinned,
   input  logic        req_new_anonymous,
   input  logic        req_new_has_handles,
   output logic [1:0]  res_status,
   output logic [5:0]  res_frame,
   output logic        res_write_back,
   output logic [15:0] res_victim_table_id,
   output logic [31:0] res_victim_page_number
);
   localparam int IW = $clog2(ENTRIES);
   localparam int NP = 1 << IW;

   logic [ENTRIES-1:0]  valid_ff, pinned_ff, anon_ff, hand_ff;
   logic [TABLE_BITS-1:0] tab_ff [ENTRIES];
   logic [PAGE_BITS-1:0]  page_ff [ENTRIES];
   logic [IW-1:0]         rank_ff [ENTRIES];

   op_type                op_ff;
   logic [TABLE_BITS-1:0] kt_ff;
   logic [PAGE_BITS-1:0]  kp_ff;
   logic                  np_ff, na_ff, nh_ff;

   logic [TABLE_BITS-1:0] kt_in;
   logic [PAGE_BITS-1:0]  kp_in;
   always_comb begin
      kt_in = '0;
      kp_in = '0;
      for (int b = 0; b < TABLE_BITS; b++) if (b < 16) kt_in[b] = req_table_id[b];
      for (int b = 0; b < PAGE_BITS; b++) if (b < 32) kp_in[b] = req_page_number[b];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff <= op_type'(req_operation);
         kt_ff <= kt_in;
         kp_ff <= kp_in;
         np_ff <= req_new_pinned;
         na_ff <= req_new_anonymous;
         nh_ff <= req_new_has_handles;
      end
   end

   // Search over all entries: free slot, key hit and oldest unpinned.
   logic [ENTRIES-1:0] hit_vec, free_vec, cand_vec;
   logic [IW-1:0]      free_idx, hit_idx, vic_idx;
   logic               free_any, hit_any, vic_any;
   logic               tv [2*NP];
   logic [IW-1:0]      ti [2*NP];
   logic [IW-1:0]      tr [2*NP];
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         hit_vec[i]  = valid_ff[i] && tab_ff[i] == kt_ff && page_ff[i] == kp_ff;
         free_vec[i] = !valid_ff[i];
         cand_vec[i] = valid_ff[i] && !pinned_ff[i];
      end
      free_idx = '0; hit_idx = '0; free_any = 1'b0; hit_any = 1'b0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (free_vec[i]) begin free_any = 1'b1; free_idx = IW'(i); end
         if (hit_vec[i])  begin hit_any = 1'b1;  hit_idx = IW'(i); end
      end
      // A tree of compares picks the oldest unpinned entry in log2(ENTRIES) levels.
      // Unpinned valid ranks are distinct, so no ties arise.
      for (int n = 0; n < 2*NP; n++) begin
         tv[n] = 1'b0;
         ti[n] = '0;
         tr[n] = '0;
      end
      for (int i = 0; i < ENTRIES; i++) begin
         tv[NP+i] = cand_vec[i];
         ti[NP+i] = IW'(i);
         tr[NP+i] = rank_ff[i];
      end
      for (int n = NP - 1; n >= 1; n--) begin
         if (tv[2*n] && (!tv[2*n+1] || tr[2*n] > tr[2*n+1])) begin
            tv[n] = 1'b1;
            ti[n] = ti[2*n];
            tr[n] = tr[2*n];
         end else begin
            tv[n] = tv[2*n+1];
            ti[n] = ti[2*n+1];
            tr[n] = tr[2*n+1];
         end
      end
      vic_any = tv[1];
      vic_idx = ti[1];
   end

   // Decide the update.
   logic          do_ins, do_touch, do_flags;
   logic [IW-1:0] tgt;
   logic [IW:0]   limit;
   status_type    st;
   always_comb begin
      do_ins = 1'b0; do_touch = 1'b0; do_flags = 1'b0;
      tgt = '0; limit = '0; st = ST_OK;
      case (op_ff)
         OP_ADD: begin
            if (free_any) begin do_ins = 1'b1; tgt = free_idx; limit = (IW+1)'(ENTRIES); end
            else st = ST_FULL;
         end
         OP_EVICT: begin
            if (vic_any) begin
               do_ins = 1'b1; tgt = vic_idx; limit = {1'b0, rank_ff[vic_idx]};
            end else st = ST_PINNED;
         end
         default: begin
            if (!hit_any) st = ST_NOTFOUND;
            else begin
               tgt = hit_idx;
               if (op_ff == OP_TOUCH) begin do_touch = 1'b1; limit = {1'b0, rank_ff[hit_idx]}; end
               else do_flags = 1'b1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         pinned_ff <= '0;
         anon_ff   <= '0;
         hand_ff   <= '0;
      end else if (cmd.commit) begin
         for (int i = 0; i < ENTRIES; i++)
            if ((do_ins || do_touch) && valid_ff[i] && {1'b0, rank_ff[i]} < limit)
               rank_ff[i] <= rank_ff[i] + 1'b1;
         if (do_ins) begin
            valid_ff[tgt] <= 1'b1;
            tab_ff[tgt]   <= kt_ff;
            page_ff[tgt]  <= kp_ff;
         end
         if (do_ins || do_touch) rank_ff[tgt] <= '0;
         if (do_ins || do_flags) begin
            pinned_ff[tgt] <= np_ff;
            anon_ff[tgt]   <= na_ff;
            hand_ff[tgt]   <= nh_ff;
         end
      end
   end

   logic is_vic;
   assign is_vic = op_ff == OP_EVICT && vic_any;
   always_comb begin
      res_status = st;
      res_frame  = (st == ST_OK) ? 6'(tgt) : 6'd0;
      res_write_back = is_vic && (!anon_ff[vic_idx] || hand_ff[vic_idx]);
      res_victim_table_id    = '0;
      res_victim_page_number = '0;
      if (is_vic) begin
         for (int b = 0; b < TABLE_BITS; b++)
            if (b < 16) res_victim_table_id[b] = tab_ff[vic_idx][b];
         for (int b = 0; b < PAGE_BITS; b++)
            if (b < 32) res_victim_page_number[b] = page_ff[vic_idx][b];
      end
   end
endmodule

/* hw/rtl/lrup_ctrl.sv */
// Controller of the LRU frame table: handshake sequencing and result-valid register.
// Depends on lrup_pkg.
`timescale 1ns / 1ps
module lrup_ctrl
   import lrup_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output cmd_type cmd,
   output logic    load_rsp
);
   typedef enum logic [0:0] {S_IDLE, S_EXEC} state_type;
   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   logic can_load;
   assign can_load = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      load_rsp     = 1'b0;
      req_stall    = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin cmd.capture = 1'b1; state_in = S_EXEC; end
         end
         S_EXEC: begin
            if (can_load) begin
               cmd.commit = 1'b1; load_rsp = 1'b1;
               rsp_valid_in = 1'b1; state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
   assign rsp_valid = rsp_valid_ff;
endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for the LRU frame table with pinning.
// Depends on lrup_pkg and lru_replacement_with_pinning; predicts every result word.
`timescale 1ns / 1ps
module tb;
   import lrup_pkg::*;

   localparam int NFRAMES = 64;

   // One result word as the block reports it.
   typedef struct packed {
      status_type  status;
      logic [5:0]  frame;
      logic        write_back;
      logic [15:0] vic_table;
      logic [31:0] vic_page;
   } outcome_t;

   // One stimulus row. When known is set, the typed-in outcome is checked too.
   typedef struct packed {
      op_type      op;
      logic [15:0] tbl;
      logic [31:0] page;
      logic        pin;
      logic        anon;
      logic        hnd;
      logic        known;
      outcome_t    want;
   } row_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_operation = '0;
   logic [15:0] req_table_id = '0;
   logic [31:0] req_page_number = '0;
   logic        req_new_pinned = 1'b0;
   logic        req_new_anonymous = 1'b0;
   logic        req_new_has_handles = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [5:0]  rsp_frame;
   logic        rsp_write_back;
   logic [15:0] rsp_victim_table_id;
   logic [31:0] rsp_victim_page_number;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   lru_replacement_with_pinning uut (.*);

   // Shadow copy of the frame table, used to predict each result word.
   logic        sh_valid [NFRAMES];
   logic [15:0] sh_table [NFRAMES];
   logic [31:0] sh_page  [NFRAMES];
   logic        sh_pin   [NFRAMES];
   logic        sh_anon  [NFRAMES];
   logic        sh_hnd   [NFRAMES];
   int          sh_rank  [NFRAMES];

   outcome_t pending_results[$];
   row_t     row_q[$];
   int       send_idle_pct = 0;
   int       recv_idle_pct = 0;
   bit       failed = 0;

   // Every valid entry whose rank is below the limit ages by one.
   function automatic void age_below(int limit);
      for (int i = 0; i < NFRAMES; i++)
         if (sh_valid[i] && sh_rank[i] < limit) sh_rank[i]++;
   endfunction

   function automatic void put_page(int f, row_t r);
      sh_valid[f] = 1'b1;
      sh_table[f] = r.tbl;
      sh_page[f]  = r.page;
      sh_pin[f]   = r.pin;
      sh_anon[f]  = r.anon;
      sh_hnd[f]   = r.hnd;
      sh_rank[f]  = 0;
   endfunction

   // Applies one word to the shadow table and returns the result it must cause.
   function automatic outcome_t apply_word(row_t r);
      outcome_t o;
      int f;
      int rk;
      o = '0;
      o.status = ST_OK;
      f = -1;
      case (r.op)
         OP_ADD: begin
            for (int i = NFRAMES - 1; i >= 0; i--)
               if (!sh_valid[i]) f = i;
            if (f < 0) o.status = ST_FULL;
            else begin
               age_below(NFRAMES);
               put_page(f, r);
               o.frame = f[5:0];
            end
         end
         OP_EVICT: begin
            // Least recent unpinned entry; ties cannot occur since ranks are distinct.
            for (int i = 0; i < NFRAMES; i++)
               if (sh_valid[i] && !sh_pin[i] && (f < 0 || sh_rank[i] > sh_rank[f])) f = i;
            if (f < 0) o.status = ST_PINNED;
            else begin
               rk = sh_rank[f];
               o.write_back = !sh_anon[f] || sh_hnd[f];
               o.vic_table  = sh_table[f];
               o.vic_page   = sh_page[f];
               age_below(rk);
               put_page(f, r);
               o.frame = f[5:0];
            end
         end
         default: begin
            for (int i = NFRAMES - 1; i >= 0; i--)
               if (sh_valid[i] && sh_table[i] == r.tbl && sh_page[i] == r.page) f = i;
            if (f < 0) o.status = ST_NOTFOUND;
            else begin
               if (r.op == OP_TOUCH) begin
                  age_below(sh_rank[f]);
                  sh_rank[f] = 0;
               end else begin
                  sh_pin[f]  = r.pin;
                  sh_anon[f] = r.anon;
                  sh_hnd[f]  = r.hnd;
               end
               o.frame = f[5:0];
            end
         end
      endcase
      return o;
   endfunction

   // Resident keys, so that touches and set-flags often hit.
   function automatic row_t pick_row();
      row_t r;
      int live[$];
      int k;
      r = '0;
      r.op   = op_type'($urandom_range(0, 3));
      r.tbl  = 16'($urandom_range(0, 7));
      r.page = 32'($urandom_range(0, 15));
      if ($urandom_range(0, 9) == 0) begin
         r.tbl  = 16'($urandom);
         r.page = $urandom;
      end
      // Pinning is kept rare so that evictions mostly find a victim.
      r.pin  = ($urandom_range(0, 5) == 0);
      r.anon = 1'($urandom);
      r.hnd  = 1'($urandom);
      for (int i = 0; i < NFRAMES; i++) if (sh_valid[i]) live.push_back(i);
      if ((r.op == OP_TOUCH || r.op == OP_FLAGS) && live.size() > 0 &&
          $urandom_range(0, 3) != 0) begin
         k = live[$urandom_range(0, live.size() - 1)];
         r.tbl  = sh_table[k];
         r.page = sh_page[k];
      end
      return r;
   endfunction

   function automatic row_t mk(op_type op, logic [15:0] t, logic [31:0] p,
                               logic pin, logic an, logic h);
      row_t r;
      r = '0;
      r.op = op; r.tbl = t; r.page = p; r.pin = pin; r.anon = an; r.hnd = h;
      return r;
   endfunction

   function automatic row_t mk_known(row_t r, status_type s, logic [5:0] f);
      r.known = 1'b1;
      r.want = '0;
      r.want.status = s;
      r.want.frame = f;
      return r;
   endfunction

   // Sender: holds each word until it is accepted, idles at random between words.
   task automatic send_row(row_t r);
      while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_operation       <= r.op;
      req_table_id        <= r.tbl;
      req_page_number     <= r.page;
      req_new_pinned      <= r.pin;
      req_new_anonymous   <= r.anon;
      req_new_has_handles <= r.hnd;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // The word was accepted at this edge, so predict it now.
      begin
         outcome_t o;
         o = apply_word(r);
         if (r.known && o !== r.want) begin
            $display("%0t directed row disagrees: expected %h, predicted %h", $time, r.want, o);
            failed = 1;
         end
         pending_results.push_back(o);
      end
   endtask

   // Receiver: random stall, checks each accepted result word against the oldest prediction.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               $display("%0t unexpected result word: status %0d frame %0d",
                        $time, rsp_status, rsp_frame);
               failed = 1;
            end else begin
               outcome_t w;
               w = pending_results.pop_front();
               if (rsp_status !== w.status || rsp_frame !== w.frame ||
                   rsp_write_back !== w.write_back ||
                   rsp_victim_table_id !== w.vic_table ||
                   rsp_victim_page_number !== w.vic_page) begin
                  $display("%0t mismatch: expected st=%0d fr=%0d wb=%0d vt=%h vp=%h",
                           $time, w.status, w.frame, w.write_back, w.vic_table, w.vic_page);
                  $display("%0t            actual st=%0d fr=%0d wb=%0d vt=%h vp=%h",
                           $time, rsp_status, rsp_frame, rsp_write_back,
                           rsp_victim_table_id, rsp_victim_page_number);
                  failed = 1;
               end
            end
         end
         rsp_stall <= (recv_idle_pct > 0 && $urandom_range(0, 99) < recv_idle_pct);
      end
   end

   initial begin
      int wait_cycles;
      for (int i = 0; i < NFRAMES; i++) begin
         sh_valid[i] = 1'b0; sh_pin[i] = 1'b0; sh_anon[i] = 1'b0; sh_hnd[i] = 1'b0;
         sh_table[i] = '0; sh_page[i] = '0; sh_rank[i] = 0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: empty-table cases, extremes of the keys, pinning and write-back.
      row_q.push_back(mk_known(mk(OP_EVICT, 16'h0, 32'h0, 1'b0, 1'b0, 1'b0),
                               ST_PINNED, 6'd0));
      row_q.push_back(mk_known(mk(OP_TOUCH, 16'h0, 32'h0, 1'b0, 1'b0, 1'b0),
                               ST_NOTFOUND, 6'd0));
      row_q.push_back(mk_known(mk(OP_FLAGS, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1),
                               ST_NOTFOUND, 6'd0));
      row_q.push_back(mk_known(mk(OP_ADD, 16'h0, 32'h0, 1'b0, 1'b0, 1'b0), ST_OK, 6'd0));
      row_q.push_back(mk_known(mk(OP_ADD, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1),
                               ST_OK, 6'd1));
      row_q.push_back(mk(OP_ADD, 16'hAAAA, 32'h5555_5555, 1'b0, 1'b1, 1'b0));
      row_q.push_back(mk(OP_ADD, 16'h5555, 32'hAAAA_AAAA, 1'b0, 1'b1, 1'b1));
      row_q.push_back(mk(OP_ADD, 16'h0, 32'h0, 1'b0, 1'b0, 1'b0));   // duplicate key
      row_q.push_back(mk(OP_TOUCH, 16'h0, 32'h0, 1'b0, 1'b0, 1'b0));
      row_q.push_back(mk(OP_FLAGS, 16'h0, 32'h0, 1'b1, 1'b0, 1'b0));
      row_q.push_back(mk(OP_EVICT, 16'h1234, 32'h8765_4321, 1'b0, 1'b0, 1'b1));
      row_q.push_back(mk(OP_EVICT, 16'h4321, 32'h1234_5678, 1'b1, 1'b0, 1'b0));
      row_q.push_back(mk(OP_EVICT, 16'h0001, 32'h0000_0001, 1'b1, 1'b1, 1'b0));
      row_q.push_back(mk(OP_TOUCH, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0));
      row_q.push_back(mk(OP_FLAGS, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0));
      row_q.push_back(mk(OP_EVICT, 16'h0002, 32'h0000_0002, 1'b1, 1'b0, 1'b0));
      row_q.push_back(mk(OP_EVICT, 16'h0003, 32'h0000_0003, 1'b1, 1'b0, 1'b0));
      row_q.push_back(mk(OP_EVICT, 16'h0004, 32'h0000_0004, 1'b1, 1'b0, 1'b0));
      row_q.push_back(mk(OP_TOUCH, 16'h7777, 32'h7777_7777, 1'b0, 1'b0, 1'b0));
      foreach (row_q[i]) send_row(row_q[i]);

      // Fill the table so that the full case is reached, then random traffic.
      for (int i = 0; i < 64; i++)
         send_row(mk(OP_ADD, 16'($urandom_range(0, 7)), 32'($urandom_range(0, 15)),
                     $urandom_range(0, 7) == 0, 1'($urandom), 1'($urandom)));
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 47 : 0;
         recv_idle_pct = (phase == 0) ? 47 : (phase == 1) ? 14 : 0;
         for (int n = 0; n < 650; n++) begin
            // Unpin now and then so that eviction keeps finding victims.
            if ($urandom_range(0, 49) == 0)
               for (int i = 0; i < NFRAMES; i++)
                  if (sh_valid[i] && sh_pin[i])
                     send_row(mk(OP_FLAGS, sh_table[i], sh_page[i], 1'b0,
                                 1'($urandom), 1'($urandom)));
            send_row(pick_row());
         end
      end
      req_valid <= 1'b0;
      recv_idle_pct = 0;

      wait_cycles = 0;
      while (pending_results.size() > 0 && wait_cycles < 10000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (4) @(posedge clock);
      if (!failed && pending_results.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Hard stop in case the handshake never completes.
   initial begin
      #400000;
      $display("Mismatches found");
      $finish;
   end
endmodule
